// ===== hw/rtl/kef_pkg.sv =====
// shared types, codes and defaults for the keyed event fifo
package kef_pkg;

	// default number of stored records
	localparam int DEPTH_DEFAULT = 16;

	// command codes
	localparam logic [2:0] FUNC_APPEND = 3'd0;
	localparam logic [2:0] FUNC_PEEK   = 3'd1;
	localparam logic [2:0] FUNC_POP    = 3'd2;
	localparam logic [2:0] FUNC_CANCEL = 3'd3;
	localparam logic [2:0] FUNC_ALTER  = 3'd4;
	localparam logic [2:0] FUNC_FIND   = 3'd5;

	// result status codes
	localparam logic [1:0] STATUS_OK   = 2'd0;
	localparam logic [1:0] STATUS_MISS = 2'd1;
	localparam logic [1:0] STATUS_FULL = 2'd2;

	// command request
	typedef struct packed {
		logic [2:0]  func;
		logic [31:0] when;
		logic [31:0] new_when;
		logic [31:0] tag;
		logic [7:0]  priority_req;
	} req_t;

	// command result
	typedef struct packed {
		logic [1:0]  status;
		logic        hit;
		logic [31:0] out_when;
		logic [31:0] out_tag;
		logic [7:0]  out_priority;
		logic [4:0]  count;
	} rsp_t;

	// one stored record
	typedef struct packed {
		logic [31:0] key;
		logic [31:0] desc;
		logic [7:0]  prio;
	} entry_t;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_HEAD,
		ST_SCAN,
		ST_SHIFT
	} state_t;

endpackage

// ===== hw/rtl/kef_ram.sv =====
// generic single write port ram with registered read
module kef_ram #(
	parameter int WIDTH = 72,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

// ===== hw/rtl/keyed_event_fifo.sv =====
// keyed event fifo top level: record store, key search sequencer and result register
//
// Bounded fifo of event records (key, tag, priority) in a single ram. A request is
// taken when start is high and busy is low; its result appears on rsp with done high
// for exactly one cycle, one per request, and cannot be held off, so capture it
// when done is seen. Append, unknown commands and any command on an empty store give
// their result in the cycle after the request; peek and pop first read the head
// record. Find, alter and cancel scan the records one per cycle through the ram read
// port and the single key comparator, and pop and cancel then move each later record
// down one slot per cycle through the same port. count reports the number of stored
// records after the command, in its low five bits.
module keyed_event_fifo #(
	parameter int DEPTH = kef_pkg::DEPTH_DEFAULT
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  kef_pkg::req_t req,
	output logic          done,
	output kef_pkg::rsp_t rsp
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int EW = $bits(kef_pkg::entry_t);

	kef_pkg::state_t state_q, state_d;
	logic [CW-1:0]   count_q, count_d;
	logic            done_q, done_d;
	logic            match_q, match_d;
	logic [AW-1:0]   idx_q, idx_d;
	logic [AW-1:0]   found_q, found_d;
	kef_pkg::entry_t rec_q, rec_d;
	kef_pkg::req_t   req_q, req_d;
	kef_pkg::rsp_t   rsp_q, rsp_d;

	logic            ram_we;
	logic [AW-1:0]   ram_waddr;
	logic [AW-1:0]   ram_raddr;
	kef_pkg::entry_t ram_wdata;
	logic [EW-1:0]   ram_rdata;
	kef_pkg::entry_t rd_entry;

	logic [CW-1:0]   idx_nxt;
	logic [CW-1:0]   cnt_m1;
	logic            key_hit;
	logic            scan_match;
	kef_pkg::entry_t scan_rec;
	logic [AW-1:0]   scan_idx;
	kef_pkg::entry_t alter_rec;

	// result with no record
	function automatic kef_pkg::rsp_t rsp_plain(logic [1:0] st, logic [CW-1:0] c);
		kef_pkg::rsp_t r;
		r = '0;
		r.status = st;
		r.count = 5'(c);
		return r;
	endfunction

	// result that returns a record
	function automatic kef_pkg::rsp_t rsp_hit(kef_pkg::entry_t e, logic [CW-1:0] c);
		kef_pkg::rsp_t r;
		r.status = kef_pkg::STATUS_OK;
		r.hit = 1'b1;
		r.out_when = e.key;
		r.out_tag = e.desc;
		r.out_priority = e.prio;
		r.count = 5'(c);
		return r;
	endfunction

	// record store
	kef_ram #(
		.WIDTH(EW),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign rd_entry = kef_pkg::entry_t'(ram_rdata);

	// index arithmetic and the shared key comparator
	assign idx_nxt = CW'(idx_q) + CW'(1);
	assign cnt_m1  = count_q - CW'(1);
	assign key_hit = (rd_entry.key == req_q.when);

	// running last-match tracking for alter and find
	assign scan_match = match_q | key_hit;
	assign scan_rec   = key_hit ? rd_entry : rec_q;
	assign scan_idx   = key_hit ? idx_q : found_q;

	always_comb begin
		alter_rec = scan_rec;
		alter_rec.key = req_q.new_when;
		alter_rec.desc = req_q.tag;
	end

	// sequencer: next state, store control and result
	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		done_d    = 1'b0;
		match_d   = match_q;
		idx_d     = idx_q;
		found_d   = found_q;
		rec_d     = rec_q;
		req_d     = req_q;
		rsp_d     = rsp_q;
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = rd_entry;
		ram_raddr = (state_q == kef_pkg::ST_IDLE) ? '0 : idx_nxt[AW-1:0];

		unique case (state_q)
			kef_pkg::ST_IDLE: begin
				if (start) begin
					req_d   = req;
					idx_d   = '0;
					match_d = 1'b0;
					unique case (req.func)
						kef_pkg::FUNC_APPEND: begin
							if (count_q == CW'(DEPTH)) begin
								rsp_d  = rsp_plain(kef_pkg::STATUS_FULL, count_q);
								done_d = 1'b1;
							end else begin
								ram_we         = 1'b1;
								ram_waddr      = count_q[AW-1:0];
								ram_wdata.key  = req.when;
								ram_wdata.desc = req.tag;
								ram_wdata.prio = req.priority_req;
								count_d        = count_q + CW'(1);
								rsp_d          = rsp_plain(kef_pkg::STATUS_OK, count_d);
								done_d         = 1'b1;
							end
						end
						kef_pkg::FUNC_PEEK, kef_pkg::FUNC_POP: begin
							if (count_q == '0) begin
								rsp_d  = rsp_plain(kef_pkg::STATUS_MISS, count_q);
								done_d = 1'b1;
							end else begin
								state_d = kef_pkg::ST_HEAD;
							end
						end
						kef_pkg::FUNC_CANCEL, kef_pkg::FUNC_ALTER, kef_pkg::FUNC_FIND: begin
							if (count_q == '0) begin
								rsp_d  = rsp_plain(kef_pkg::STATUS_MISS, count_q);
								done_d = 1'b1;
							end else begin
								state_d = kef_pkg::ST_SCAN;
							end
						end
						default: begin
							rsp_d  = rsp_plain(kef_pkg::STATUS_OK, count_q);
							done_d = 1'b1;
						end
					endcase
				end
			end

			// head record is on the read port
			kef_pkg::ST_HEAD: begin
				rec_d = rd_entry;
				if (req_q.func == kef_pkg::FUNC_POP) begin
					if (idx_nxt < count_q) begin
						state_d = kef_pkg::ST_SHIFT;
					end else begin
						count_d = cnt_m1;
						rsp_d   = rsp_hit(rd_entry, cnt_m1);
						done_d  = 1'b1;
						state_d = kef_pkg::ST_IDLE;
					end
				end else begin
					rsp_d   = rsp_hit(rd_entry, count_q);
					done_d  = 1'b1;
					state_d = kef_pkg::ST_IDLE;
				end
			end

			// one record compared per cycle, next read already issued
			kef_pkg::ST_SCAN: begin
				if (req_q.func == kef_pkg::FUNC_CANCEL) begin
					priority if (key_hit) begin
						rec_d = rd_entry;
						if (idx_nxt < count_q) begin
							state_d = kef_pkg::ST_SHIFT;
						end else begin
							count_d = cnt_m1;
							rsp_d   = rsp_hit(rd_entry, cnt_m1);
							done_d  = 1'b1;
							state_d = kef_pkg::ST_IDLE;
						end
					end else if (idx_nxt == count_q) begin
						rsp_d   = rsp_plain(kef_pkg::STATUS_MISS, count_q);
						done_d  = 1'b1;
						state_d = kef_pkg::ST_IDLE;
					end else begin
						idx_d = idx_nxt[AW-1:0];
					end
				end else begin
					if (idx_nxt == count_q) begin
						done_d  = 1'b1;
						state_d = kef_pkg::ST_IDLE;
						priority if (!scan_match) begin
							rsp_d = rsp_plain(kef_pkg::STATUS_MISS, count_q);
						end else if (req_q.func == kef_pkg::FUNC_ALTER) begin
							ram_we    = 1'b1;
							ram_waddr = scan_idx;
							ram_wdata = alter_rec;
							rsp_d     = rsp_hit(alter_rec, count_q);
						end else begin
							rsp_d = rsp_hit(scan_rec, count_q);
						end
					end else begin
						match_d = scan_match;
						rec_d   = scan_rec;
						found_d = scan_idx;
						idx_d   = idx_nxt[AW-1:0];
					end
				end
			end

			// close the gap: record idx+1 moves into slot idx, record idx+2 is fetched
			kef_pkg::ST_SHIFT: begin
				ram_we    = 1'b1;
				ram_raddr = idx_q + AW'(2);
				if (idx_nxt < cnt_m1) begin
					idx_d = idx_nxt[AW-1:0];
				end else begin
					count_d = cnt_m1;
					rsp_d   = rsp_hit(rec_q, cnt_m1);
					done_d  = 1'b1;
					state_d = kef_pkg::ST_IDLE;
				end
			end

			default: begin
				state_d = kef_pkg::ST_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= kef_pkg::ST_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
			match_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			done_q  <= done_d;
			match_q <= match_d;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		idx_q   <= idx_d;
		found_q <= found_d;
		rec_q   <= rec_d;
		req_q   <= req_d;
		rsp_q   <= rsp_d;
	end

	assign busy = (state_q != kef_pkg::ST_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

endmodule
